>>> sv/irc_pkg.sv
package irc_pkg;

  localparam int RouteEntriesDefault = 8;
  localparam logic [31:0] ClassMask = 32'hF000_0000;
  localparam logic [31:0] MulticastClass = 32'hE000_0000;

  localparam logic [3:0] V_LOCAL = 4'd0;
  localparam logic [3:0] V_VERSION = 4'd1;
  localparam logic [3:0] V_CHECKSUM = 4'd2;
  localparam logic [3:0] V_SHORT = 4'd3;
  localparam logic [3:0] V_FRAGMENT = 4'd4;
  localparam logic [3:0] V_MULTICAST = 4'd5;
  localparam logic [3:0] V_BROADCAST = 4'd6;
  localparam logic [3:0] V_HOST_UNREACH = 4'd7;
  localparam logic [3:0] V_FORWARD = 4'd8;
  localparam logic [3:0] V_TTL = 4'd9;
  localparam logic [3:0] V_PROTO_UNREACH = 4'd10;

  typedef struct packed {
    logic        mode;
    logic [31:0] header_word;
    logic        last_word;
    logic [15:0] frame_len;
    logic [2:0]  entry_index;
    logic        entry_valid;
    logic [31:0] entry_local_addr;
    logic [31:0] entry_mask;
    logic [31:0] entry_net_addr;
  } in_item_t;

  typedef struct packed {
    logic [3:0]  verdict;
    logic [7:0]  protocol;
    logic [5:0]  header_bytes;
    logic [15:0] payload_len;
    logic [31:0] src_addr;
    logic [31:0] dest_addr;
    logic [2:0]  route_slot;
    logic [7:0]  new_ttl;
    logic [15:0] new_checksum;
  } out_item_t;

  // Controller to datapath.
  typedef struct packed {
    logic take_word;   // capture and sum the input word
    logic write_route; // write a route entry
    logic start_walk;  // pre-check verdict and reset walk
    logic walk_step;   // examine one route entry
    logic finish;      // result taken, clear header state
  } irc_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic early_done;  // verdict settled before the walk
    logic walk_done;   // walk has settled the verdict
  } irc_status_t;

endpackage

>>> sv/irc_ctrl.sv
module irc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_mode,
  input  logic                in_last,
  output logic                out_valid,
  input  logic                out_ready,
  output irc_pkg::irc_cmd_t   cmd,
  input  irc_pkg::irc_status_t status
);
  import irc_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHECK = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] state, state_next;
  logic accept;

  assign in_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_mode) begin
            cmd.write_route = 1'b1;
          end else begin
            cmd.take_word = 1'b1;
            if (in_last) state_next = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        cmd.start_walk = 1'b1;
        state_next = status.early_done ? S_OUT : S_WALK;
      end
      S_WALK: begin
        cmd.walk_step = 1'b1;
        if (status.walk_done) state_next = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
  a_last_goes_check: assert property (@(posedge clk) disable iff (rst)
    (accept && !in_mode && in_last) |=> (state == S_CHECK))
    else $error("last word did not start classification");
endmodule

>>> sv/irc_datapath.sv
module irc_datapath #(
  parameter int ROUTE_ENTRIES = irc_pkg::RouteEntriesDefault
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 gateway_enable,
  input  irc_pkg::in_item_t    in_item,
  input  irc_pkg::irc_cmd_t    cmd,
  output irc_pkg::irc_status_t status,
  output irc_pkg::out_item_t   out_item
);
  import irc_pkg::*;

  localparam int IW = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

  logic [3:0]  word_count;
  logic        overrun;
  logic [20:0] running_sum;
  logic [31:0] first_word_fields, flags_word, ttl_proto_sum_word;
  logic [31:0] captured_source, captured_dest;
  logic        len_short;

  logic [ROUTE_ENTRIES-1:0] route_valid;
  logic [31:0] route_local_addr [ROUTE_ENTRIES];
  logic [31:0] route_mask [ROUTE_ENTRIES];
  logic [31:0] route_net_addr [ROUTE_ENTRIES];

  logic [IW:0] walk_idx;
  logic        second_pass;
  logic [3:0]  verdict;
  logic [2:0]  slot;
  logic [7:0]  nttl;
  logic [15:0] nchk;

  // Header field decode.
  logic [3:0]  ihl;
  logic [5:0]  hbytes;
  logic [15:0] total;
  logic [7:0]  ttl, proto;
  logic [16:0] f1;
  logic [15:0] folded;
  logic [3:0]  pre_verdict;
  logic        pre_done;

  assign ihl = first_word_fields[27:24];
  assign hbytes = {ihl, 2'b00};
  assign total = first_word_fields[15:0];
  assign ttl = ttl_proto_sum_word[31:24];
  assign proto = ttl_proto_sum_word[23:16];
  assign f1 = {12'd0, running_sum[20:16]} + {1'b0, running_sum[15:0]};
  assign folded = f1[15:0] + {15'd0, f1[16]};

  always_comb begin
    pre_done = 1'b1;
    pre_verdict = V_LOCAL;
    if (first_word_fields[31:28] != 4'd4) pre_verdict = V_VERSION;
    else if (ihl < 4'd5 || overrun || word_count != ihl || folded != 16'hFFFF)
      pre_verdict = V_CHECKSUM;
    else if (len_short) pre_verdict = V_SHORT;
    else if (flags_word[13]) pre_verdict = V_FRAGMENT;
    else if ((captured_dest & ClassMask) == MulticastClass) pre_verdict = V_MULTICAST;
    else pre_done = 1'b0;
  end
  assign status.early_done = pre_done;

  // One route entry per walk step.
  logic [IW-1:0] ei;
  logic          at_end, ent_ok;
  logic [31:0]   nm;
  assign ei = walk_idx[IW-1:0];
  assign at_end = (walk_idx >= (IW+1)'(ROUTE_ENTRIES));
  assign ent_ok = !at_end && route_valid[ei];
  assign nm = ~route_mask[ei];

  // New checksum: remove old checksum field and 0x100 for the TTL step.
  logic [15:0] s_adj;
  logic [31:0] s32;
  logic [16:0] g1;
  logic [15:0] g2;
  assign s32 = {11'd0, running_sum} - {16'd0, ttl_proto_sum_word[15:0]} - 32'h100;
  assign g1 = {1'b0, s32[15:0]} + {1'b0, s32[31:16]};
  assign g2 = g1[15:0] + {15'd0, g1[16]};
  assign s_adj = g2;

  logic walk_done;
  always_comb begin
    walk_done = 1'b0;
    if (!second_pass) begin
      if (ent_ok && (captured_dest == route_local_addr[ei])) walk_done = 1'b1;
      else if (ent_ok && nm != 32'd0 && (captured_dest & nm) == nm) walk_done = 1'b1;
      else if (!ent_ok && !gateway_enable) walk_done = 1'b1;
    end else begin
      if (!ent_ok) walk_done = 1'b1;
      else if ((captured_dest & route_mask[ei]) == route_net_addr[ei]) walk_done = 1'b1;
    end
  end
  assign status.walk_done = walk_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      route_valid <= '0;
    end else if (cmd.write_route && 32'(in_item.entry_index) < ROUTE_ENTRIES) begin
      route_valid[IW'(in_item.entry_index)] <= in_item.entry_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_route && 32'(in_item.entry_index) < ROUTE_ENTRIES) begin
      route_local_addr[IW'(in_item.entry_index)] <= in_item.entry_local_addr;
      route_mask[IW'(in_item.entry_index)] <= in_item.entry_mask;
      route_net_addr[IW'(in_item.entry_index)] <= in_item.entry_net_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      word_count <= '0;
      overrun <= 1'b0;
      running_sum <= '0;
      first_word_fields <= '0;
      flags_word <= '0;
      ttl_proto_sum_word <= '0;
      captured_source <= '0;
      captured_dest <= '0;
    end else if (cmd.take_word) begin
      if (word_count < 4'd15) begin
        case (word_count)
          4'd0: first_word_fields <= in_item.header_word;
          4'd1: flags_word <= in_item.header_word;
          4'd2: ttl_proto_sum_word <= in_item.header_word;
          4'd3: captured_source <= in_item.header_word;
          4'd4: captured_dest <= in_item.header_word;
          default: ;
        endcase
        running_sum <= running_sum + 21'(in_item.header_word[31:16])
                       + 21'(in_item.header_word[15:0]);
        word_count <= word_count + 4'd1;
      end else begin
        overrun <= 1'b1;
      end
    end
  end

  // Frame length compare needs the raw total; take it on the last word.
  always_ff @(posedge clk) begin
    if (cmd.take_word && in_item.last_word) begin
      if (word_count == 4'd0)
        len_short <= in_item.frame_len < in_item.header_word[15:0];
      else
        len_short <= in_item.frame_len < total;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_walk) begin
      verdict <= pre_verdict;
      slot <= '0;
      nttl <= '0;
      nchk <= '0;
      walk_idx <= '0;
      second_pass <= 1'b0;
    end else if (cmd.walk_step) begin
      if (!second_pass) begin
        if (ent_ok && (captured_dest == route_local_addr[ei])) begin
          slot <= 3'(ei);
          verdict <= (proto == 8'd17 || proto == 8'd6 || proto == 8'd1)
                     ? V_LOCAL : V_PROTO_UNREACH;
        end else if (ent_ok && nm != 32'd0 && (captured_dest & nm) == nm) begin
          verdict <= V_BROADCAST;
        end else if (!ent_ok) begin
          if (!gateway_enable) verdict <= V_HOST_UNREACH;
          second_pass <= 1'b1;
          walk_idx <= '0;
        end else begin
          walk_idx <= walk_idx + 1'b1;
        end
      end else begin
        if (!ent_ok) begin
          verdict <= V_HOST_UNREACH;
        end else if ((captured_dest & route_mask[ei]) == route_net_addr[ei]) begin
          slot <= 3'(ei);
          if (ttl <= 8'd1) begin
            verdict <= V_TTL;
          end else begin
            verdict <= V_FORWARD;
            nttl <= ttl - 8'd1;
            nchk <= ~s_adj;
          end
        end else begin
          walk_idx <= walk_idx + 1'b1;
        end
      end
    end
  end

  always_comb begin
    out_item.verdict = verdict;
    out_item.protocol = proto;
    out_item.header_bytes = hbytes;
    out_item.payload_len = (total >= 16'(hbytes)) ? total - 16'(hbytes) : 16'd0;
    out_item.src_addr = captured_source;
    out_item.dest_addr = captured_dest;
    out_item.route_slot = slot;
    out_item.new_ttl = nttl;
    out_item.new_checksum = nchk;
  end

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    running_sum <= 21'd1966050) else $error("running sum out of range");
  a_fwd_fields: assert property (@(posedge clk) disable iff (rst)
    (cmd.finish && verdict != V_FORWARD) |-> (nttl == 8'd0 && nchk == 16'd0))
    else $error("forward fields set on non-forward verdict");
  a_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (word_count == 4'd0 && running_sum == 21'd0))
    else $error("header state not cleared");
endmodule

>>> sv/ipv4_receive_classifier.sv
// After the last header word the controller passes through the check state, then
// either straight to the output state or through the route table walk first.
// Throughput: one header word per cycle within a datagram, then one datagram in
// flight at a time until its result is taken. Route writes are taken only while idle.
// Reset (rst, synchronous, active high) clears the gateway enable, the header
// state and all route valid bits.
module ipv4_receive_classifier #(
  parameter int ROUTE_ENTRIES = irc_pkg::RouteEntriesDefault
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  irc_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output irc_pkg::out_item_t  out_data
);
  import irc_pkg::*;

  // The single configuration register lets unmatched datagrams be forwarded.
  logic gateway_enable;
  irc_cmd_t cmd;
  irc_status_t status;

  always_ff @(posedge clk) begin
    if (rst) gateway_enable <= 1'b0;
    else if (cfg_we) gateway_enable <= cfg_wdata;
  end

  // The controller sequences word intake, the early checks and the table walk.
  irc_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_data.mode), .in_last(in_data.last_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .cmd(cmd), .status(status)
  );

  // The datapath holds the header capture, checksum sum and route table.
  irc_datapath #(.ROUTE_ENTRIES(ROUTE_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .gateway_enable(gateway_enable),
    .in_item(in_data), .cmd(cmd), .status(status), .out_item(out_data)
  );
endmodule
